// ===== sv/torus_point_depth_rasterizer_defines.svh =====
// Assertion macros shared by the checker of the torus point depth rasterizer.
`ifndef TORUS_POINT_DEPTH_RASTERIZER_DEFINES_SVH
`define TORUS_POINT_DEPTH_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on the block clock and idle during reset.
`define TPDR_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock and idle during reset.
`define TPDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tpdr_pkg.sv =====
// Types, constants and the quarter-wave sine table of the torus point depth rasterizer.
package tpdr_pkg;

    localparam int COLS       = 80;
    localparam int ROWS       = 24;
    localparam int PHASE_BITS = 12;
    localparam int CELLS      = COLS * ROWS;
    localparam int CELL_AW    = $clog2(CELLS);
    localparam int QTR        = 1 << (PHASE_BITS - 2);
    localparam int ONE_Q14    = 16384;
    localparam int DEN_OFFSET = 5 * ONE_Q14;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int GLYPH_W    = 4;
    localparam int GLYPH_MAX  = 11;
    localparam int DEPTH_W    = 16;
    localparam int ROM_W      = 15;
    localparam int DW         = 20;
    localparam int PW         = 2 * DW;
    localparam int DEN_W      = DW - 1;
    localparam int DIV_BITS   = 31;
    localparam int STEP_W     = 5;

    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_PLOT  = 1'b1;

    // Register indexes of the configuration port.
    localparam logic CFG_ROT_A = 1'b0;
    localparam logic CFG_ROT_B = 1'b1;

    // Trig lookup order.
    localparam int TI_SA = 0;
    localparam int TI_CA = 1;
    localparam int TI_SB = 2;
    localparam int TI_CB = 3;
    localparam int TI_ST = 4;
    localparam int TI_CT = 5;
    localparam int TI_SR = 6;
    localparam int TI_CR = 7;
    localparam int TRIG_LAST = 8;

    // Multiply sequence: each step leaves its Q14 product in slot of same number.
    localparam int MS_CH   = 0;
    localparam int MS_CHSA = 1;
    localparam int MS_STCA = 2;
    localparam int MS_CHCA = 3;
    localparam int MS_STSA = 4;
    localparam int MS_CRH  = 5;
    localparam int MS_CD   = 6;
    localparam int MS_CRCT = 7;
    localparam int MS_P1   = 8;
    localparam int MS_P2   = 9;
    localparam int MS_Q1   = 10;
    localparam int MS_Q2   = 11;
    localparam int MS_CDCA = 12;
    localparam int MS_L1   = 13;
    localparam int MS_CDSA = 14;
    localparam int MS_L3   = 15;
    localparam int MUL_LAST = 15;

    // Projection steps.
    localparam int PS_DP  = 0;
    localparam int PS_DQ  = 1;
    localparam int PS_FIN = 2;

    localparam int DS_GO   = 0;
    localparam int DS_WAIT = 1;

    typedef struct packed {
        logic                  action;
        logic [PHASE_BITS-1:0] tube_phase;
        logic [PHASE_BITS-1:0] ring_phase;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] glyph;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TRIG,
        S_MUL,
        S_DIV,
        S_PROJ,
        S_READ,
        S_CMP
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_TRIG,
        OP_MUL,
        OP_DIVGO,
        OP_PROJ,
        OP_RDMEM,
        OP_UPDATE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic out_busy;
    } t_sts;

    typedef logic [ROM_W-1:0] t_qsin_tab [QTR+1];

    // Quarter wave in Q14, from a Q30 Taylor series rounded to nearest.
    function automatic t_qsin_tab build_qsin();
        t_qsin_tab   tab;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k <= QTR; k++) begin
            x    = (64'(k) * 64'd6746518852) >> PHASE_BITS;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            tab[k] = ROM_W'((sum + 32768) >>> 16);
        end
        return tab;
    endfunction

    localparam t_qsin_tab QSIN_TAB = build_qsin();

endpackage

// ===== sv/tpdr_div.sv =====
// Restoring divider that forms the saturated inverse depth 2^30 / den, one bit a cycle.
module tpdr_div
    import tpdr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic [DEPTH_W-1:0] o_quo
);

    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_rem;
    logic [DIV_BITS-1:0] r_quo;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DEN_W:0] rem_sh;
    logic           fits;

    // The dividend is a single one at bit thirty.
    assign rem_sh = {r_rem, (r_cnt == STEP_W'(DIV_BITS - 1))};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= STEP_W'(DIV_BITS - 1);
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], fits};
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = (|r_quo[DIV_BITS-1:DEPTH_W]) ? '1 : r_quo[DEPTH_W-1:0];

endmodule

// ===== sv/tpdr_ctrl.sv =====
// Sequencer: clear sweeps, or a sample's lookup, multiply, divide, project and depth test.
module tpdr_ctrl
    import tpdr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_action,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step + STEP_W'(1);
        case (r_state)
            S_CLEAR: begin
                n_step = '0;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) n_state = (i_in_action == ACT_CLEAR) ? S_CLEAR : S_TRIG;
            end
            S_TRIG: begin
                if (r_step == STEP_W'(TRIG_LAST)) begin
                    n_state = S_MUL;
                    n_step  = '0;
                end
            end
            S_MUL: begin
                if (r_step == STEP_W'(MUL_LAST)) begin
                    n_state = S_DIV;
                    n_step  = STEP_W'(DS_GO);
                end
            end
            S_DIV: begin
                n_step = STEP_W'(DS_WAIT);
                if (r_step == STEP_W'(DS_WAIT) && i_sts.div_done) begin
                    n_state = S_PROJ;
                    n_step  = STEP_W'(PS_DP);
                end
            end
            S_PROJ: begin
                if (r_step == STEP_W'(PS_FIN)) n_state = S_READ;
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.step = r_step;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: o_cmd.op = OP_CLEAR;
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_TRIG:  o_cmd.op = OP_TRIG;
            S_MUL:   o_cmd.op = OP_MUL;
            S_DIV:   o_cmd.op = (r_step == STEP_W'(DS_GO)) ? OP_DIVGO : OP_NONE;
            S_PROJ:  o_cmd.op = OP_PROJ;
            S_READ:  o_cmd.op = OP_RDMEM;
            S_CMP:   o_cmd.op = i_sts.out_busy ? OP_NONE : OP_UPDATE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== sv/tpdr_dp.sv =====
// Datapath: trig table, shared multiplier, divider, projection, depth store and output register.
module tpdr_dp
    import tpdr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_word  i_in_word,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [PHASE_BITS-1:0] i_cfg_data,
    input  logic      i_out_stall,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int XW   = PW + 6;
    localparam int XN_W = 16;
    localparam int NN_W = 9;
    localparam logic signed [XW-1:0] X_OFF  = XW'(COLS / 2) << 30;
    localparam logic signed [XW-1:0] Y_OFF  = XW'(ROWS / 2) << 30;
    localparam logic signed [XW-1:0] P_BIAS = (XW'(1) << 30) - XW'(1);

    logic [PHASE_BITS-1:0] r_rot_a, r_rot_b, r_tube, r_ring;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_a <= '0;
            r_rot_b <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ROT_A) r_rot_a <= i_cfg_data;
            else r_rot_b <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_tube <= i_in_word.tube_phase;
            r_ring <= i_in_word.ring_phase;
        end
    end

    // Trig lookups: table addressed in one step, registered table data folded by sign the next.
    logic [PHASE_BITS-1:0] base, ph;
    logic [1:0]            quad;
    logic [PHASE_BITS-3:0] rofs;
    logic [PHASE_BITS-2:0] rom_addr;
    logic [ROM_W-1:0]      r_rom_q;
    logic                  r_rom_neg;
    logic signed [DW-1:0]  r_trig [8];

    always_comb begin
        case (i_cmd.step[2:1])
            2'd0:    base = r_rot_a;
            2'd1:    base = r_rot_b;
            2'd2:    base = r_tube;
            default: base = r_ring;
        endcase
        ph       = base + (i_cmd.step[0] ? PHASE_BITS'(QTR) : '0);
        quad     = ph[PHASE_BITS-1:PHASE_BITS-2];
        rofs     = ph[PHASE_BITS-3:0];
        rom_addr = quad[0] ? (PHASE_BITS-1)'(QTR) - (PHASE_BITS-1)'(rofs)
                           : (PHASE_BITS-1)'(rofs);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_TRIG) begin
            if (i_cmd.step < STEP_W'(TRIG_LAST)) begin
                r_rom_q   <= QSIN_TAB[rom_addr];
                r_rom_neg <= quad[1];
            end
            if (i_cmd.step != '0) begin
                r_trig[3'(i_cmd.step - STEP_W'(1))] <=
                    r_rom_neg ? -signed'(DW'(r_rom_q)) : signed'(DW'(r_rom_q));
            end
        end
    end

    logic signed [DW-1:0] sa, ca, sb, cb, st, ct, sr, cr, h;
    assign sa = r_trig[TI_SA];
    assign ca = r_trig[TI_CA];
    assign sb = r_trig[TI_SB];
    assign cb = r_trig[TI_CB];
    assign st = r_trig[TI_ST];
    assign ct = r_trig[TI_CT];
    assign sr = r_trig[TI_SR];
    assign cr = r_trig[TI_CR];
    assign h  = ct + DW'(2 * ONE_Q14);

    // Shared multiplier with Q14 truncation toward zero.
    logic signed [DW-1:0] r_m [16];
    logic signed [DW-1:0] t_v, den_v, p_v, q_v, lum_v;
    logic signed [DW-1:0] mul_a, mul_b, mq;
    logic signed [PW-1:0] prod, q14_bias, q14_full;
    logic [DEPTH_W-1:0]   div_quo;
    logic                 div_done;

    assign t_v   = r_m[MS_CHCA] - r_m[MS_STSA];
    assign den_v = r_m[MS_CHSA] + r_m[MS_STCA] + DW'(DEN_OFFSET);
    assign p_v   = r_m[MS_P1] - r_m[MS_P2];
    assign q_v   = r_m[MS_Q1] + r_m[MS_Q2];
    assign lum_v = r_m[MS_L1] - r_m[MS_CDSA] - r_m[MS_STCA] - r_m[MS_L3];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.op == OP_PROJ) begin
            mul_a = signed'(DW'(div_quo));
            mul_b = (i_cmd.step == STEP_W'(PS_DP)) ? p_v : q_v;
        end else begin
            case (i_cmd.step)
                STEP_W'(MS_CH):   begin mul_a = sr;              mul_b = h;  end
                STEP_W'(MS_CHSA): begin mul_a = r_m[MS_CH];      mul_b = sa; end
                STEP_W'(MS_STCA): begin mul_a = st;              mul_b = ca; end
                STEP_W'(MS_CHCA): begin mul_a = r_m[MS_CH];      mul_b = ca; end
                STEP_W'(MS_STSA): begin mul_a = st;              mul_b = sa; end
                STEP_W'(MS_CRH):  begin mul_a = cr;              mul_b = h;  end
                STEP_W'(MS_CD):   begin mul_a = sr;              mul_b = ct; end
                STEP_W'(MS_CRCT): begin mul_a = cr;              mul_b = ct; end
                STEP_W'(MS_P1):   begin mul_a = r_m[MS_CRH];     mul_b = cb; end
                STEP_W'(MS_P2):   begin mul_a = t_v;             mul_b = sb; end
                STEP_W'(MS_Q1):   begin mul_a = r_m[MS_CRH];     mul_b = sb; end
                STEP_W'(MS_Q2):   begin mul_a = t_v;             mul_b = cb; end
                STEP_W'(MS_CDCA): begin mul_a = r_m[MS_CD];      mul_b = ca; end
                STEP_W'(MS_L1):   begin
                    mul_a = r_m[MS_STSA] - r_m[MS_CDCA];
                    mul_b = cb;
                end
                STEP_W'(MS_CDSA): begin mul_a = r_m[MS_CD];      mul_b = sa; end
                STEP_W'(MS_L3):   begin mul_a = r_m[MS_CRCT];    mul_b = sb; end
                default:          begin mul_a = '0;              mul_b = '0; end
            endcase
        end
    end

    assign prod     = mul_a * mul_b;
    assign q14_bias = prod[PW-1] ? PW'(ONE_Q14 - 1) : '0;
    assign q14_full = (prod + q14_bias) >>> 14;
    assign mq       = q14_full[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MUL) r_m[4'(i_cmd.step)] <= mq;
    end

    // Inverse depth; the denominator is held at least one.
    logic [DEN_W-1:0] den_c;
    assign den_c = (den_v < 1) ? DEN_W'(1) : den_v[DEN_W-1:0];

    tpdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIVGO),
        .i_den   (den_c),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Projection to screen cell and shading index.
    logic signed [PW-1:0]   r_dp, r_dq;
    logic signed [XW-1:0]   sx, sy, bx, by, tx, ty;
    logic signed [DW-1:0]   lb, ln;
    logic signed [XN_W-1:0] r_xn, r_yn;
    logic signed [NN_W-1:0] r_nn;

    assign sx = (XW'(r_dp) <<< 3) + (XW'(r_dp) <<< 1) + X_OFF;
    assign sy = (XW'(r_dq) <<< 4) - XW'(r_dq) + Y_OFF;
    assign bx = sx[XW-1] ? P_BIAS : '0;
    assign by = sy[XW-1] ? P_BIAS : '0;
    assign tx = (sx + bx) >>> 30;
    assign ty = (sy + by) >>> 30;
    assign lb = lum_v[DW-1] ? DW'(2047) : '0;
    assign ln = (lum_v + lb) >>> 11;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PROJ) begin
            if (i_cmd.step == STEP_W'(PS_DP)) r_dp <= prod;
            if (i_cmd.step == STEP_W'(PS_DQ)) r_dq <= prod;
            if (i_cmd.step == STEP_W'(PS_FIN)) begin
                r_xn <= tx[XN_W-1:0];
                r_yn <= ty[XN_W-1:0];
                r_nn <= ln[NN_W-1:0];
            end
        end
    end

    // Depth store.
    logic [DEPTH_W-1:0] mem [CELLS];
    logic [DEPTH_W-1:0] r_rd;
    logic [CELL_AW-1:0] r_idx, r_clr_addr, idx, rd_addr;
    logic               r_in_range, in_range, nearer, plot;

    assign in_range = (r_xn > 0) && (r_xn < XN_W'(COLS)) && (r_yn > 0) && (r_yn < XN_W'(ROWS));
    assign idx      = CELL_AW'(r_xn) + CELL_AW'(COLS) * CELL_AW'(r_yn);
    assign rd_addr  = in_range ? idx : '0;
    assign nearer   = div_quo > r_rd;
    assign plot     = (i_cmd.op == OP_UPDATE) && r_in_range && nearer;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLEAR) mem[r_clr_addr] <= '0;
        else if (plot) mem[r_idx] <= div_quo;
        if (i_cmd.op == OP_RDMEM) begin
            r_rd       <= mem[rd_addr];
            r_idx      <= rd_addr;
            r_in_range <= in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_addr <= '0;
        else if (i_cmd.op == OP_CLEAR) begin
            r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + CELL_AW'(1);
        end
    end

    // Output register.
    logic        r_out_valid;
    t_out_word   r_out_word;
    logic [GLYPH_W-1:0] glyph_c;

    assign glyph_c = (r_nn < 0) ? '0 :
                     (r_nn > NN_W'(GLYPH_MAX)) ? GLYPH_W'(GLYPH_MAX) : r_nn[GLYPH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (plot) r_out_valid <= 1'b1;
        else if (!i_out_stall) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (plot) begin
            r_out_word.col   <= r_xn[COL_W-1:0];
            r_out_word.row   <= r_yn[ROW_W-1:0];
            r_out_word.glyph <= glyph_c;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == CELL_AW'(CELLS - 1));
    assign o_sts.div_done = div_done;
    assign o_sts.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;

endmodule

// ===== sv/torus_point_depth_rasterizer.sv =====
// Top level of the torus point depth rasterizer: controller and datapath.
//
// Each input word either clears the depth store (action 0) or plots one torus
// surface sample given by its tube and ring phases (action 1). A plotted sample
// is rotated by the two frame angles written through the configuration port
// (index 0 is rot_a_phase, index 1 is rot_b_phase), projected with an inverse
// depth of 2^30 over the denominator, and emitted as column, row and glyph only
// when its column is 1 to 79, its row is 1 to 23 and the new depth is greater
// than the one stored there. A plot word is taken, then goes through the eight
// sine and cosine lookups through the registered quarter-wave table, the
// single shared multiplier, the bit-serial divider that forms the inverse
// depth (a start step, the quotient bits one at a time and a step that sees
// it finish), projection, the depth store read and the update, which waits
// while the output register is stalled. The divider takes the largest share.
// A clear word, and the first pass after reset, sweep the 1920-entry depth
// store one entry a cycle, and the input is stalled while the sweep runs;
// configuration writes are taken at any time and should only be made while the
// block is idle. At most one result word comes from each plot word and it
// waits in an output register, so the next input word is taken while the
// previous result is still stalled.
module torus_point_depth_rasterizer
    import tpdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [PHASE_BITS-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // The sequencer sees the handshake, the action bit and the datapath status.
    tpdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_word.action),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    tpdr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== sv/tpdr_checker.sv =====
// Port-level checker for the torus point depth rasterizer and its bind.
`include "torus_point_depth_rasterizer_defines.svh"

module tpdr_checker
    import tpdr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_word              i_in_word,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_word             o_out_word,
    input logic                  i_cfg_we,
    input logic                  i_cfg_idx,
    input logic [PHASE_BITS-1:0] i_cfg_data
);

    `TPDR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result word dropped")
    `TPDR_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_word), "result word changed")
    `TPDR_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after word")
    `TPDR_ASSERT(a_out_range, o_out_valid, o_out_word.glyph <= GLYPH_MAX && o_out_word.col != 0 && o_out_word.row != 0 && o_out_word.col < COLS && o_out_word.row < ROWS, "result word out of range")

endmodule

bind torus_point_depth_rasterizer tpdr_checker u_chk (.*);

// ===== tb/sv/torus_point_depth_rasterizer_tb.sv =====
// Self-checking testbench for the torus point depth rasterizer.
module torus_point_depth_rasterizer_tb;
    import tpdr_pkg::*;

    // The run is stopped here whatever happens, clearing sweeps and stalls included.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // A clear word sweeps the whole depth store, so after the last result the
    // block may still be busy for this long before it is safe to reconfigure.
    localparam int SETTLE       = 2100;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_WORDS  = 145;
    localparam int CALM_WORDS   = 120;

    typedef enum logic {
        CHK_NONE,   // expected outcome typed in: no result word
        CHK_PRED    // expected outcome taken from the predictor
    } t_chk;

    typedef struct {
        logic                  action;
        logic [PHASE_BITS-1:0] tube;
        logic [PHASE_BITS-1:0] ring;
        t_chk                  chk;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;
    logic      i_cfg_we;
    logic      i_cfg_idx;
    logic [PHASE_BITS-1:0] i_cfg_data;

    // Model state: sine quarter wave, depth per cell and the two frame angles.
    int                    sine_quarter [QTR+1];
    int unsigned           cell_depth [CELLS];
    logic [PHASE_BITS-1:0] angle_a;
    logic [PHASE_BITS-1:0] angle_b;

    t_out_word pending_cells [$];
    int        fail_count;
    int        cycle_count;
    bit        hold_req;
    bit        calm;

    torus_point_depth_rasterizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The quarter wave is rebuilt here from the Taylor series in Q30 and then
    // rounded to Q14, so that the table inside the block is checked as well.
    function automatic void fill_sine();
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        for (int k = 0; k <= QTR; k++) begin
            x    = (longint'(k) * 2 * 64'd3373259426) >> PHASE_BITS;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum -= longint'(term);
                end else begin
                    sum += longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sine_quarter[k] = int'((sum + 32768) >> 16);
        end
    endfunction

    function automatic longint sine_of(logic [PHASE_BITS-1:0] ph);
        int r;
        r = int'(ph[PHASE_BITS-3:0]);
        case (ph[PHASE_BITS-1:PHASE_BITS-2])
            2'd0: return sine_quarter[r];
            2'd1: return sine_quarter[QTR-r];
            2'd2: return -sine_quarter[r];
            default: return -sine_quarter[QTR-r];
        endcase
    endfunction

    function automatic longint cosine_of(logic [PHASE_BITS-1:0] ph);
        return sine_of(ph + PHASE_BITS'(QTR));
    endfunction

    // Q14 product, truncated toward zero as signed division does.
    function automatic longint qmul(longint a, longint b);
        return (a * b) / ONE_Q14;
    endfunction

    // Rotates, projects and depth-tests one sample; returns 1 and the cell
    // when it is plotted, updating the depth copy as the block should.
    function automatic bit plot_sample(logic [PHASE_BITS-1:0] tube,
                                       logic [PHASE_BITS-1:0] ring,
                                       output t_out_word pix);
        longint sa, ca, sb, cb, st, ct, sr, cr;
        longint h, ch, den, d, t, crh, p, q, xn, yn, cd, lum, nn;
        int     idx;
        sa = sine_of(angle_a);
        ca = cosine_of(angle_a);
        sb = sine_of(angle_b);
        cb = cosine_of(angle_b);
        st = sine_of(tube);
        ct = cosine_of(tube);
        sr = sine_of(ring);
        cr = cosine_of(ring);
        h   = ct + 2 * ONE_Q14;
        ch  = qmul(sr, h);
        den = qmul(ch, sa) + qmul(st, ca) + 5 * ONE_Q14;
        if (den < 1) begin
            den = 1;
        end
        d = (64'd1 << 30) / den;
        if (d > 65535) begin
            d = 65535;
        end
        t   = qmul(ch, ca) - qmul(st, sa);
        crh = qmul(cr, h);
        p   = qmul(crh, cb) - qmul(t, sb);
        q   = qmul(crh, sb) + qmul(t, cb);
        xn  = (longint'(COLS / 2) * (64'd1 << 30) + 10 * d * p) / (64'd1 << 30);
        yn  = (longint'(ROWS / 2) * (64'd1 << 30) + 15 * d * q) / (64'd1 << 30);
        cd  = qmul(sr, ct);
        lum = qmul(qmul(st, sa) - qmul(cd, ca), cb)
            - qmul(cd, sa) - qmul(st, ca) - qmul(qmul(cr, ct), sb);
        nn  = (8 * lum) / ONE_Q14;
        pix = '0;
        if (!(yn > 0 && yn < ROWS && xn > 0 && xn < COLS)) begin
            return 1'b0;
        end
        idx = int'(xn) + COLS * int'(yn);
        if (d <= cell_depth[idx]) begin
            return 1'b0;
        end
        cell_depth[idx] = int'(d);
        if (nn < 0) begin
            nn = 0;
        end
        if (nn > GLYPH_MAX) begin
            nn = GLYPH_MAX;
        end
        pix.col   = COL_W'(xn);
        pix.row   = ROW_W'(yn);
        pix.glyph = GLYPH_W'(nn);
        return 1'b1;
    endfunction

    // Offers one word, optionally after an idle burst, and books what the
    // block should answer once the word has been taken.
    task automatic send_word(logic act, logic [PHASE_BITS-1:0] tube,
                             logic [PHASE_BITS-1:0] ring, t_chk chk);
        t_in_word  w;
        t_out_word pix;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        w.action     = act;
        w.tube_phase = tube;
        w.ring_phase = ring;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (act == ACT_CLEAR) begin
            foreach (cell_depth[i]) cell_depth[i] = 0;
        end else if (chk == CHK_PRED) begin
            if (plot_sample(tube, ring, pix)) begin
                pending_cells.push_back(pix);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_angle(logic idx, logic [PHASE_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ROT_A) begin
            angle_a = val;
        end else begin
            angle_b = val;
        end
    endtask

    // Directed words with both angles at zero. Repeated samples must lose the
    // depth test; a clear lets them win again.
    t_row directed [] = '{
        '{ACT_CLEAR, 12'd0,    12'd0,    CHK_NONE},
        '{ACT_PLOT,  12'd0,    12'd0,    CHK_PRED},
        '{ACT_PLOT,  12'd0,    12'd0,    CHK_NONE},
        '{ACT_PLOT,  12'd4095, 12'd4095, CHK_PRED},
        '{ACT_PLOT,  12'd4095, 12'd0,    CHK_PRED},
        '{ACT_PLOT,  12'd0,    12'd4095, CHK_PRED},
        '{ACT_PLOT,  12'd1024, 12'd0,    CHK_PRED},
        '{ACT_PLOT,  12'd2048, 12'd0,    CHK_PRED},
        '{ACT_PLOT,  12'd3072, 12'd0,    CHK_PRED},
        '{ACT_PLOT,  12'd0,    12'd1024, CHK_PRED},
        '{ACT_PLOT,  12'd0,    12'd2048, CHK_PRED},
        '{ACT_PLOT,  12'd0,    12'd3072, CHK_PRED},
        '{ACT_PLOT,  12'd3072, 12'd1024, CHK_PRED},
        '{ACT_PLOT,  12'd3072, 12'd1024, CHK_NONE},
        '{ACT_PLOT,  12'd2730, 12'd1365, CHK_PRED},
        '{ACT_PLOT,  12'd1365, 12'd2730, CHK_PRED},
        '{ACT_PLOT,  12'd2048, 12'd2048, CHK_PRED},
        '{ACT_CLEAR, 12'd4095, 12'd4095, CHK_NONE},
        '{ACT_PLOT,  12'd0,    12'd0,    CHK_PRED},
        '{ACT_PLOT,  12'd3072, 12'd1024, CHK_PRED},
        '{ACT_PLOT,  12'd2560, 12'd3584, CHK_PRED},
        '{ACT_PLOT,  12'd512,  12'd512,  CHK_PRED}
    };

    // Frame angles per phase; extremes first, then random ones.
    logic [PHASE_BITS-1:0] phase_a [7];
    logic [PHASE_BITS-1:0] phase_b [7];

    initial begin
        fill_sine();
        foreach (cell_depth[i]) cell_depth[i] = 0;
        angle_a     = '0;
        angle_b     = '0;
        fail_count  = 0;
        hold_req    = 1'b0;
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_ROT_A;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_word(directed[i].action, directed[i].tube, directed[i].ring,
                      directed[i].chk);
        end
        wait_drained();

        phase_a = '{12'd4095, 12'd0,    12'd2048, 12'd1024, 12'd0, 12'd0, 12'd0};
        phase_b = '{12'd4095, 12'd4095, 12'd1024, 12'd0,    12'd0, 12'd0, 12'd0};
        for (int ph = 4; ph < 7; ph++) begin
            phase_a[ph] = PHASE_BITS'($urandom_range(0, 4095));
            phase_b[ph] = PHASE_BITS'($urandom_range(0, 4095));
        end

        for (int ph = 0; ph < 7; ph++) begin
            write_angle(CFG_ROT_A, phase_a[ph]);
            write_angle(CFG_ROT_B, phase_b[ph]);
            // Each frame opens on a clear; a few stray clears and whole-turn
            // sweeps of one phase land in between.
            send_word(ACT_CLEAR, PHASE_BITS'($urandom), PHASE_BITS'($urandom), CHK_NONE);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 6 && n == PHASE_WORDS - CALM_WORDS) begin
                    calm = 1'b1;
                end
                if (ph == 2 && n == 40) begin
                    hold_req = 1'b1;
                end
                if (ph == 3 && n == 70) begin
                    wait_drained();
                end
                if ($urandom_range(0, 99) < 2) begin
                    send_word(ACT_CLEAR, PHASE_BITS'($urandom), PHASE_BITS'($urandom),
                              CHK_NONE);
                end else if ($urandom_range(0, 3) == 0) begin
                    send_word(ACT_PLOT, PHASE_BITS'(n * 28), PHASE_BITS'($urandom),
                              CHK_PRED);
                end else begin
                    send_word(ACT_PLOT, PHASE_BITS'($urandom), PHASE_BITS'($urandom),
                              CHK_PRED);
                end
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request and none
    // once the run has gone calm.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
    end

    // Every result word taken is matched against the oldest expected cell.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cells.size() == 0) begin
                $error("result word with none expected: col %0d row %0d glyph %0d",
                       o_out_word.col, o_out_word.row, o_out_word.glyph);
                fail_count++;
            end else begin
                want = pending_cells.pop_front();
                if (o_out_word.col !== want.col) begin
                    $error("col: expected %0d, got %0d", want.col, o_out_word.col);
                    fail_count++;
                end
                if (o_out_word.row !== want.row) begin
                    $error("row: expected %0d, got %0d", want.row, o_out_word.row);
                    fail_count++;
                end
                if (o_out_word.glyph !== want.glyph) begin
                    $error("glyph: expected %0d, got %0d", want.glyph, o_out_word.glyph);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
